FILE: src/smf_pkg.sv
`timescale 1ns / 1ps

package smf_pkg;

  // configuration register geometry
  localparam int CFG_W      = 12;
  localparam int CFG_ADDR_W = 1;
  localparam int ROW_W      = 12;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // reset values of the frame geometry
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  // first row and column that get a filtered output
  localparam int BORDER = 3;

  // parameter defaults
  localparam int KERNEL_SIZE_DEF = 3;
  localparam int MAX_COLS_DEF    = 2048;
  localparam int PIXEL_BITS_DEF  = 8;

endpackage

FILE: src/stream_median_filter_3x3.sv
// throughput: one beat per cycle when the output is not stalled; line memory read-modify-write
//   and a pipelined odd-even transposition sort, one compare-exchange stage per register
// reset: asynchronous, active low; afterwards the whole line memory is cleared,
//   one column a cycle, with s_axis_tready low
`timescale 1ns / 1ps

module stream_median_filter_3x3 #(
  parameter int KERNEL_SIZE = smf_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_COLS    = smf_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS  = smf_pkg::PIXEL_BITS_DEF,
  localparam int TDATA_W    = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [smf_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [smf_pkg::CFG_W-1:0]       cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,   // pixel_in
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDATA_W-1:0]              m_axis_tdata    // pixel_out
);

  localparam int WIN_N  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINES  = KERNEL_SIZE - 1;
  localparam int LINE_W = LINES * PIXEL_BITS;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int MID    = WIN_N / 2;
  localparam int WLAST_RST =
    ((smf_pkg::WIDTH_RST < MAX_COLS) ? smf_pkg::WIDTH_RST : MAX_COLS) - 1;
  localparam logic [smf_pkg::CFG_W:0] MAX_COLS_L = (smf_pkg::CFG_W + 1)'(MAX_COLS);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIXEL_BITS-1:0] win_t;

  // clearing pass
  logic             clr_q;
  logic [COL_W-1:0] clr_addr_q;

  // frame geometry and position
  logic [COL_W-1:0]          wlast_q, wlast_new;
  logic [smf_pkg::ROW_W-1:0] hlast_q;
  logic [smf_pkg::CFG_W:0]   wsat;
  logic [COL_W-1:0]          col_q, col_d;
  logic [smf_pkg::ROW_W-1:0] row_q, row_d;

  // handshake
  logic             s_acc;
  logic             rdy1, rdy_o, adv1;
  logic [WIN_N:0]   rdy_s;

  // memory stage
  logic              v1_q;
  pix_t              s1_pix_q;
  logic [COL_W-1:0]  s1_col_q;
  logic              s1_mid_q;
  logic [LINE_W-1:0] mem [MAX_COLS];
  logic [LINE_W-1:0] rd_q;
  logic              fwd_q;
  logic [LINE_W-1:0] fwd_data_q;
  logic [LINE_W-1:0] lines, line_wdata;
  logic              mem_we;
  logic [COL_W-1:0]  mem_waddr;
  logic [LINE_W-1:0] mem_wdata;
  logic [KERNEL_SIZE-1:0][PIXEL_BITS-1:0] col_pix;

  // window and sort pipeline
  win_t           win_q, win_d;
  logic [WIN_N:0] vs_q;
  win_t           sort_q [WIN_N+1];
  win_t           sort_d [WIN_N+1];
  logic [WIN_N:0] mid_q;
  pix_t           pix_q [WIN_N+1];

  // output register
  logic vo_q;
  pix_t out_q;

  // ready chain from the output back to the input
  always_comb begin
    rdy_o        = !vo_q || m_axis_tready;
    rdy_s[WIN_N] = !vs_q[WIN_N] || rdy_o;
    for (int k = WIN_N - 1; k >= 0; k--) begin
      rdy_s[k] = !vs_q[k] || rdy_s[k+1];
    end
    rdy1 = !v1_q || rdy_s[0];
  end

  assign adv1          = v1_q && rdy_s[0];
  assign s_axis_tready = rdy1 && !clr_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // saturated width of a configuration write
  always_comb begin
    wsat = {1'b0, cfg_data_i};
    if (wsat == '0) begin
      wsat = (smf_pkg::CFG_W + 1)'(1);
    end else if (wsat > MAX_COLS_L) begin
      wsat = MAX_COLS_L;
    end
    wlast_new = COL_W'(wsat - (smf_pkg::CFG_W + 1)'(1));
  end

  // column and row counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_q >= wlast_q) begin
      col_d = '0;
      row_d = (row_q >= hlast_q) ? '0 : row_q + smf_pkg::ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
    end
  end

  // line words seen by the item in the memory stage, and its write-back
  always_comb begin
    lines      = fwd_q ? fwd_data_q : rd_q;
    line_wdata = {s1_pix_q, lines[LINE_W-1:PIXEL_BITS]};
    for (int i = 0; i < LINES; i++) begin
      col_pix[i] = lines[i*PIXEL_BITS +: PIXEL_BITS];
    end
    col_pix[KERNEL_SIZE-1] = s1_pix_q;
  end

  // memory write port: clearing pass or write-back
  always_comb begin
    mem_we    = clr_q || adv1;
    mem_waddr = clr_q ? clr_addr_q : s1_col_q;
    mem_wdata = clr_q ? '0 : line_wdata;
  end

  // window shift by one column
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
        win_d[i*KERNEL_SIZE+j] = win_q[i*KERNEL_SIZE+j+1];
      end
      win_d[i*KERNEL_SIZE+KERNEL_SIZE-1] = col_pix[i];
    end
  end

  // odd-even transposition stages
  always_comb begin
    sort_d[0] = win_d;
    for (int k = 1; k <= WIN_N; k++) begin
      sort_d[k] = sort_q[k-1];
      for (int i = 0; i < WIN_N - 1; i++) begin
        if (((i % 2) != (k % 2)) && (sort_q[k-1][i] > sort_q[k-1][i+1])) begin
          sort_d[k][i]   = sort_q[k-1][i+1];
          sort_d[k][i+1] = sort_q[k-1][i];
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      wlast_q    <= COL_W'(WLAST_RST);
      hlast_q    <= smf_pkg::ROW_W'(smf_pkg::HEIGHT_RST - 1);
      col_q      <= '0;
      row_q      <= '0;
      v1_q       <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
      vs_q       <= '0;
      vo_q       <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + COL_W'(1);
        if (clr_addr_q == COL_W'(MAX_COLS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          smf_pkg::REG_FRAME_WIDTH: begin
            wlast_q <= wlast_new;
          end
          smf_pkg::REG_FRAME_HEIGHT: begin
            hlast_q <= (cfg_data_i == '0) ? '0 : cfg_data_i - smf_pkg::CFG_W'(1);
          end
          default: begin
          end
        endcase
      end
      if (s_acc) begin
        col_q <= col_d;
        row_q <= row_d;
        fwd_q <= adv1 && (s1_col_q == col_q);
      end
      if (rdy1) begin
        v1_q <= s_acc;
      end
      if (adv1) begin
        win_q <= win_d;
      end
      if (rdy_s[0]) begin
        vs_q[0] <= v1_q;
      end
      for (int k = 1; k <= WIN_N; k++) begin
        if (rdy_s[k]) begin
          vs_q[k] <= vs_q[k-1];
        end
      end
      if (rdy_o) begin
        vo_q <= vs_q[WIN_N];
      end
    end
  end

  // line memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (s_acc) begin
      rd_q <= mem[col_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_pix_q   <= s_axis_tdata[PIXEL_BITS-1:0];
      s1_col_q   <= col_q;
      s1_mid_q   <= (row_q >= smf_pkg::ROW_W'(smf_pkg::BORDER)) &&
                    (col_q >= COL_W'(smf_pkg::BORDER));
      fwd_data_q <= line_wdata;
    end
    if (adv1) begin
      sort_q[0] <= sort_d[0];
      mid_q[0]  <= s1_mid_q;
      pix_q[0]  <= s1_pix_q;
    end
    for (int k = 1; k <= WIN_N; k++) begin
      if (rdy_s[k] && vs_q[k-1]) begin
        sort_q[k] <= sort_d[k];
        mid_q[k]  <= mid_q[k-1];
        pix_q[k]  <= pix_q[k-1];
      end
    end
    if (rdy_o && vs_q[WIN_N]) begin
      out_q <= mid_q[WIN_N] ? sort_q[WIN_N][MID] : pix_q[WIN_N];
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = TDATA_W'(out_q);

endmodule

FILE: src/smf_checker.sv
`timescale 1ns / 1ps

module smf_checker #(
  parameter int KERNEL_SIZE = smf_pkg::KERNEL_SIZE_DEF,
  parameter int TDATA_W     = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  // beats that can be inside the block at once
  localparam int DEPTH = KERNEL_SIZE * KERNEL_SIZE + 3;
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // beats accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_no_extra_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != '0)
    else $error("output beat without a matching input beat");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("more beats in flight than pipeline stages");

endmodule

bind stream_median_filter_3x3 smf_checker #(
  .KERNEL_SIZE (KERNEL_SIZE),
  .TDATA_W     (TDATA_W)
) u_smf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
